// ===== rtl/psrma_pkg.sv =====
// shared types and constants of the per-spot ray moment accumulator
// no dependencies
`timescale 1ns / 1ps

package psrma_pkg;

  // request commands
  typedef enum logic [2:0] {
    CMD_ADD_RAY   = 3'd0,
    CMD_KILL_L1   = 3'd1,
    CMD_KILL_L2   = 3'd2,
    CMD_KILL_BACK = 3'd3,
    CMD_READ      = 3'd4,
    CMD_CLEAR     = 3'd5
  } cmd_t;

  // control sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_ADD_TAIL,
    ST_KILL_RD,
    ST_KILL_WR,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_RD_HOLD
  } state_t;

  // slot layout of one spot entry: moments 0..11, then the kill counters
  localparam logic [3:0] Q_MOMENT_FIRST = 4'd0;
  localparam logic [3:0] Q_MOMENT_LAST  = 4'd11;
  localparam logic [3:0] Q_KILL_L1      = 4'd12;
  localparam logic [3:0] Q_KILL_L2      = 4'd13;
  localparam logic [3:0] Q_KILL_BACK    = 4'd14;

  localparam int SLOT_W    = 4;
  localparam int TERM_W    = 48;
  localparam int FIRST_W   = 32;
  localparam int COUNT_W   = 32;

  // register map, word addressed by paddr[2]
  localparam logic REG_SPOTS_IN_USE = 1'b0;

  typedef struct packed {
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic        [15:0] weight;
  } ray_t;

endpackage

// ===== rtl/psrma_term_unit.sv =====
// shared multiplier that produces one moment term per step
// depends on psrma_pkg
`timescale 1ns / 1ps

module psrma_term_unit
  import psrma_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic [SLOT_W-1:0]        step,
  input  ray_t                     ray,
  output logic signed [TERM_W-1:0] term_r
);

  logic signed [FIRST_W-1:0] t1_r, t2_r, t3_r, t4_r;
  logic signed [FIRST_W-1:0] op_a;
  logic signed [15:0]        op_b;
  logic signed [TERM_W-1:0]  prod;
  logic signed [FIRST_W-1:0] w_ext;

  assign w_ext = $signed({16'd0, ray.weight});

  // first moments use the weight, second moments reuse a stored first moment
  always_comb begin
    op_a = w_ext;
    op_b = 16'sd1;
    case (step)
      4'd1:    begin op_a = w_ext; op_b = ray.pos_y; end
      4'd2:    begin op_a = w_ext; op_b = ray.pos_z; end
      4'd3:    begin op_a = w_ext; op_b = ray.dir_y; end
      4'd4:    begin op_a = w_ext; op_b = ray.dir_z; end
      4'd5:    begin op_a = t1_r;  op_b = ray.pos_y; end
      4'd6:    begin op_a = t2_r;  op_b = ray.pos_z; end
      4'd7:    begin op_a = t1_r;  op_b = ray.pos_z; end
      4'd8:    begin op_a = t3_r;  op_b = ray.dir_y; end
      4'd9:    begin op_a = t4_r;  op_b = ray.dir_z; end
      4'd10:   begin op_a = t1_r;  op_b = ray.dir_y; end
      4'd11:   begin op_a = t2_r;  op_b = ray.dir_z; end
      default: begin op_a = w_ext; op_b = 16'sd1;   end
    endcase
  end

  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= prod;
      case (step)
        4'd1:    t1_r <= prod[FIRST_W-1:0];
        4'd2:    t2_r <= prod[FIRST_W-1:0];
        4'd3:    t3_r <= prod[FIRST_W-1:0];
        4'd4:    t4_r <= prod[FIRST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/per_spot_ray_moment_accumulator.sv =====
// per-spot weighted moment accumulator, top level with the entry memory
// depends on psrma_pkg and psrma_term_unit
// add ray: accept, a read-modify-write step for each of the 12 moments, then a tail;
// kill: accept, counter read, incremented write; read spot: 15 results, each through
// issue, data and hold, the hold waiting out any output stall; out-of-range read: one
// result, next request after it is taken; reset (synchronous, rst_n low) and clear-all
// clear all SPOTS*16 entries; requests are taken only when idle, config writes always
`timescale 1ns / 1ps

module per_spot_ray_moment_accumulator
  import psrma_pkg::*;
#(
  parameter int SPOTS     = 256,
  parameter int ACC_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic signed [15:0] in_spot_index,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic [15:0]        in_weight,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_quantity,
  output logic signed [63:0] out_amount,
  output logic               out_spot_ok,
  output logic               out_last,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SW    = (SPOTS > 1) ? $clog2(SPOTS) : 1;
  localparam int AW    = SW + SLOT_W;
  localparam int DEPTH = SPOTS * 16;

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  state_t state_r, state_nxt;

  logic [8:0]        spots_in_use_r;
  logic [SW-1:0]     spot_r, spot_nxt;
  logic [SLOT_W-1:0] q_r, q_nxt;          // slot being read / step of an add
  logic [SLOT_W-1:0] wq_r, wq_nxt;        // slot written back in the following cycle
  logic              wpend_r, wpend_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  ray_t              ray_r, ray_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [3:0]        out_quantity_r, out_quantity_nxt;
  logic [63:0]       out_amount_r, out_amount_nxt;
  logic              out_spot_ok_r, out_spot_ok_nxt;
  logic              out_last_r, out_last_nxt;

  // entry memory: 16 slots per spot, read data registered
  logic [ACC_WIDTH-1:0] mem [DEPTH];
  logic [ACC_WIDTH-1:0] mem_rdata_r;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [ACC_WIDTH-1:0] wr_data;
  logic                 mem_we;

  logic                    in_fire, out_fire, spot_hit;
  logic [15:0]             idx_u;
  cmd_t                    cmd;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_WIDTH:0] acc_sum;
  logic [ACC_WIDTH-1:0]    acc_sat;
  logic [COUNT_W-1:0]      cnt_lo, cnt_inc;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign cmd      = cmd_t'(in_command);

  // in range when non-negative and below both the register and the table size
  assign idx_u    = in_spot_index;
  assign spot_hit = !idx_u[15] && (idx_u < 16'(spots_in_use_r)) && (idx_u < 16'(SPOTS));

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPOTS_IN_USE) ? 32'(spots_in_use_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spots_in_use_r <= 9'd256;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SPOTS_IN_USE) begin
      spots_in_use_r <= pwdata[8:0];
    end
  end

  // ---------------- term multiplier ----------------
  psrma_term_unit u_term (
    .clk    (clk),
    .en     (state_r == ST_ADD),
    .step   (q_r),
    .ray    (ray_r),
    .term_r (term)
  );

  // saturating add of the term onto the stored moment
  assign acc_sum = (ACC_WIDTH+1)'($signed(mem_rdata_r)) + (ACC_WIDTH+1)'(term);
  always_comb begin
    if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1]) begin
      acc_sat = acc_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = acc_sum[ACC_WIDTH-1:0];
    end
  end

  // kill counters live in the low bits of their slot and stick at all ones
  assign cnt_lo  = mem_rdata_r[COUNT_W-1:0];
  assign cnt_inc = (cnt_lo == {COUNT_W{1'b1}}) ? cnt_lo : cnt_lo + 32'd1;

  // ---------------- memory ----------------
  assign rd_addr = {spot_r, q_r};

  always_ff @(posedge clk) begin
    mem_rdata_r <= mem[rd_addr];
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd) inside
            CMD_ADD_RAY:                           state_nxt = spot_hit ? ST_ADD : ST_IDLE;
            CMD_KILL_L1, CMD_KILL_L2, CMD_KILL_BACK: state_nxt = spot_hit ? ST_KILL_RD : ST_IDLE;
            CMD_READ:                              state_nxt = spot_hit ? ST_RD_ISSUE : ST_RD_HOLD;
            CMD_CLEAR:                             state_nxt = ST_CLEAR;
            default:                               state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD:      if (q_r == Q_MOMENT_LAST) state_nxt = ST_ADD_TAIL;
      ST_ADD_TAIL: state_nxt = ST_IDLE;
      ST_KILL_RD:  state_nxt = ST_KILL_WR;
      ST_KILL_WR:  state_nxt = ST_IDLE;
      ST_RD_ISSUE: state_nxt = ST_RD_DATA;
      ST_RD_DATA:  state_nxt = ST_RD_HOLD;
      ST_RD_HOLD: begin
        if (out_fire) state_nxt = out_last_r ? ST_IDLE : ST_RD_ISSUE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- outputs and datapath controls ----------------
  always_comb begin
    in_stall         = (state_r != ST_IDLE);
    mem_we           = 1'b0;
    wr_addr          = {spot_r, wq_r};
    wr_data          = acc_sat;
    spot_nxt         = spot_r;
    q_nxt            = q_r;
    wq_nxt           = wq_r;
    wpend_nxt        = 1'b0;
    clr_nxt          = clr_r;
    ray_nxt          = ray_r;
    out_valid_nxt    = out_valid_r;
    out_quantity_nxt = out_quantity_r;
    out_amount_nxt   = out_amount_r;
    out_spot_ok_nxt  = out_spot_ok_r;
    out_last_nxt     = out_last_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          spot_nxt = in_spot_index[SW-1:0];
          ray_nxt  = '{pos_y: in_pos_y, pos_z: in_pos_z, dir_y: in_dir_y,
                       dir_z: in_dir_z, weight: in_weight};
          q_nxt    = Q_MOMENT_FIRST;
          case (cmd)
            CMD_KILL_L1:   q_nxt = Q_KILL_L1;
            CMD_KILL_L2:   q_nxt = Q_KILL_L2;
            CMD_KILL_BACK: q_nxt = Q_KILL_BACK;
            CMD_READ: begin
              if (!spot_hit) begin
                // out-of-range read answers with a single empty result
                out_valid_nxt    = 1'b1;
                out_quantity_nxt = Q_MOMENT_FIRST;
                out_amount_nxt   = '0;
                out_spot_ok_nxt  = 1'b0;
                out_last_nxt     = 1'b1;
              end
            end
            CMD_CLEAR:     clr_nxt = '0;
            default:       ;
          endcase
        end
      end
      ST_ADD: begin
        // read slot q while the previous slot is written back
        mem_we    = wpend_r;
        wpend_nxt = 1'b1;
        wq_nxt    = q_r;
        q_nxt     = q_r + 4'd1;
      end
      ST_ADD_TAIL: begin
        mem_we = wpend_r;
      end
      ST_KILL_RD: ;
      ST_KILL_WR: begin
        mem_we  = 1'b1;
        wr_addr = {spot_r, q_r};
        wr_data = ACC_WIDTH'(cnt_inc);
      end
      ST_RD_ISSUE: ;
      ST_RD_DATA: begin
        out_valid_nxt    = 1'b1;
        out_quantity_nxt = q_r;
        out_amount_nxt   = 64'($signed(mem_rdata_r));
        out_spot_ok_nxt  = 1'b1;
        out_last_nxt     = (q_r == Q_KILL_BACK);
      end
      ST_RD_HOLD: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          q_nxt         = q_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spot_r         <= spot_nxt;
    q_r            <= q_nxt;
    wq_r           <= wq_nxt;
    ray_r          <= ray_nxt;
    out_quantity_r <= out_quantity_nxt;
    out_amount_r   <= out_amount_nxt;
    out_spot_ok_r  <= out_spot_ok_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_quantity = out_quantity_r;
  assign out_amount   = out_amount_r;
  assign out_spot_ok  = out_spot_ok_r;
  assign out_last     = out_last_r;

`ifndef NO_ASSERTIONS
  // a write-back is only pending inside an add sequence
  a_wpend_in_add: assert property (@(posedge clk) disable iff (!rst_n)
    wpend_r |-> (state_r == ST_ADD || state_r == ST_ADD_TAIL))
    else $error("write-back pending outside add");

  // a result is only offered while the sequencer waits for it to be taken
  a_out_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_RD_HOLD)
    else $error("result valid outside hold state");

  // write-back of an add never hits the slot being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD && wpend_r) |-> wq_r != q_r)
    else $error("read and write-back on the same slot");

  // taking the final result of a run frees the block
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_HOLD && out_fire && out_last_r) |=> state_r == ST_IDLE)
    else $error("block not idle after last result");
`endif

endmodule
